// ===== sv/pfdc_pkg.sv =====
// shared types and constants for the periodic fog distance cull block
// no dependencies
package pfdc_pkg;

  localparam int unsigned CFG_AW = 3;
  localparam int unsigned CFG_DW = 32;

  localparam logic [CFG_AW-1:0] REG_CAM_X   = 3'd0;
  localparam logic [CFG_AW-1:0] REG_CAM_Y   = 3'd1;
  localparam logic [CFG_AW-1:0] REG_CAM_Z   = 3'd2;
  localparam logic [CFG_AW-1:0] REG_FOG     = 3'd3;
  localparam logic [CFG_AW-1:0] REG_PERIOD  = 3'd4;
  localparam logic [CFG_AW-1:0] REG_BASE    = 3'd5;
  localparam logic [CFG_AW-1:0] REG_LIMIT   = 3'd6;

  localparam logic [30:0] PERIOD_RESET = 31'd65536;
  localparam logic [15:0] TENTH_Q16    = 16'd6554;

  localparam int unsigned IN_DW  = 192;
  localparam int unsigned OUT_DW = 40;

  typedef struct packed {
    logic done;
    logic visible;
  } pfdc_stat_t;

endpackage

// ===== sv/periodic_fog_distance_cull.sv =====
// top level: handshakes, config registers, slot allocation and result register
// depends on pfdc_pkg and pfdc_core
//
// channel | direction | payload
// in_     | sink      | tdata origin_x/y/z, size_x/y/z; tuser first_of_range
// out_    | source    | tdata keep, slot, kept_total, range_full
// cfg_    | sink      | write enable, register index, data
//
// one item runs from accept to the next accept through three 34-step
// divisions by twice the period with a fix step each, a multiply state
// and two 32-step roots; divisions and roots share one compare-subtract unit
// in_tready is high only while the sequencer is idle
// a finished result waits in the output register; the next item may enter then
// reset is synchronous; it clears config (period resets to 65536), kept count and control state
module periodic_fog_distance_cull #(
  parameter int unsigned ROOT_CAPACITY = 131072
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // origin_x, origin_y, origin_z, size_x, size_y, size_z, zero fill
  input  logic [pfdc_pkg::IN_DW-1:0]  in_tdata,
  // first_of_range
  input  logic                        in_tuser,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // keep, slot, kept_total, range_full, zero fill
  output logic [pfdc_pkg::OUT_DW-1:0] out_tdata,
  input  logic                        cfg_we,
  input  logic [pfdc_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [pfdc_pkg::CFG_DW-1:0] cfg_wdata
);
  import pfdc_pkg::*;

  localparam int unsigned CAP_BITS = $clog2(ROOT_CAPACITY + 1);
  localparam int unsigned CW = ((CAP_BITS > 18) ? CAP_BITS : 18) + 1;
  localparam logic [CW-1:0] CAP = CW'(ROOT_CAPACITY);

  logic signed [31:0] cam_x_r, cam_y_r, cam_z_r;
  logic [30:0] fog_r, period_r;
  logic [17:0] base_r, limit_r;
  logic [17:0] kc_r, kc_nxt;
  logic signed [31:0] org_x_r, org_y_r, org_z_r;
  logic [30:0] siz_x_r, siz_y_r, siz_z_r;
  logic        ovalid_r;
  logic [OUT_DW-1:0] odata_r;

  logic        idle, take, accept;
  pfdc_stat_t  stat;
  logic [CW-1:0] base_c, room, lim;
  logic        keep;
  logic [CW-1:0] slot_w;

  assign in_tready = idle;
  assign accept    = in_tvalid && idle;
  assign take      = stat.done && (!ovalid_r || out_tready);

  pfdc_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (accept),
    .take   (take),
    .org_x  (accept ? signed'(in_tdata[31:0])  : org_x_r),
    .org_y  (accept ? signed'(in_tdata[63:32]) : org_y_r),
    .org_z  (accept ? signed'(in_tdata[95:64]) : org_z_r),
    .siz_x  (siz_x_r),
    .siz_y  (siz_y_r),
    .siz_z  (siz_z_r),
    .cam_x  (cam_x_r),
    .cam_y  (cam_y_r),
    .cam_z  (cam_z_r),
    .period (period_r),
    .fog    (fog_r),
    .idle   (idle),
    .stat   (stat)
  );

  assign base_c = ({{(CW-18){1'b0}}, base_r} < CAP) ? {{(CW-18){1'b0}}, base_r} : CAP;
  assign room   = CAP - base_c;
  assign lim    = ({{(CW-18){1'b0}}, limit_r} < room) ? {{(CW-18){1'b0}}, limit_r} : room;
  assign keep   = stat.visible && ({{(CW-18){1'b0}}, kc_r} < lim);
  assign slot_w = base_c + {{(CW-18){1'b0}}, kc_r};
  assign kc_nxt = keep ? kc_r + 18'd1 : kc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_x_r  <= '0;
      cam_y_r  <= '0;
      cam_z_r  <= '0;
      fog_r    <= '0;
      period_r <= PERIOD_RESET;
      base_r   <= '0;
      limit_r  <= '0;
      kc_r     <= '0;
      ovalid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_CAM_X:  cam_x_r  <= signed'(cfg_wdata);
          REG_CAM_Y:  cam_y_r  <= signed'(cfg_wdata);
          REG_CAM_Z:  cam_z_r  <= signed'(cfg_wdata);
          REG_FOG:    fog_r    <= cfg_wdata[30:0];
          REG_PERIOD: period_r <= cfg_wdata[30:0];
          REG_BASE:   base_r   <= cfg_wdata[17:0];
          REG_LIMIT:  limit_r  <= cfg_wdata[17:0];
          default: ;
        endcase
      end
      if (accept && in_tuser) begin
        kc_r <= '0;
      end else if (take) begin
        kc_r <= kc_nxt;
      end
      if (take) begin
        ovalid_r <= 1'b1;
      end else if (out_tready) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      org_x_r <= signed'(in_tdata[31:0]);
      org_y_r <= signed'(in_tdata[63:32]);
      org_z_r <= signed'(in_tdata[95:64]);
      siz_x_r <= in_tdata[126:96];
      siz_y_r <= in_tdata[157:127];
      siz_z_r <= in_tdata[188:158];
    end
    if (take) begin
      odata_r <= {3'd0,
                  ({{(CW-18){1'b0}}, kc_nxt} >= lim),
                  kc_nxt,
                  keep ? slot_w[16:0] : 17'd0,
                  keep};
    end
  end

  logic unused_pad;
  assign unused_pad = ^in_tdata[IN_DW-1:189];

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;

endmodule

// ===== sv/pfdc_sub.sv =====
// shared compare and subtract unit used by the division and root steps
// no dependencies
module pfdc_sub (
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        ge,
  output logic [63:0] diff
);

  assign ge   = (a >= b);
  assign diff = a - b;

endmodule

// ===== sv/pfdc_core.sv =====
// sequencer for wrap, squares and roots of one instance
// depends on pfdc_pkg and pfdc_sub
module pfdc_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               take,
  input  logic signed [31:0] org_x,
  input  logic signed [31:0] org_y,
  input  logic signed [31:0] org_z,
  input  logic [30:0]        siz_x,
  input  logic [30:0]        siz_y,
  input  logic [30:0]        siz_z,
  input  logic signed [31:0] cam_x,
  input  logic signed [31:0] cam_y,
  input  logic signed [31:0] cam_z,
  input  logic [30:0]        period,
  input  logic [30:0]        fog,
  output logic               idle,
  output pfdc_pkg::pfdc_stat_t stat
);
  import pfdc_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_FIX  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_ROOT = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]  state_r, state_nxt;
  logic [1:0]  axis_r, axis_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        rsel_r, rsel_nxt;
  logic [33:0] nsh_r, nsh_nxt;
  logic        neg_r, neg_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic signed [31:0] wd_r [3];
  logic signed [31:0] wd_nxt;
  logic        wd_we;
  logic [61:0] prod_r;
  logic [63:0] dsum_r, dsum_nxt, ssum_r, ssum_nxt;
  logic [63:0] v_r, v_nxt, res_r, res_nxt, bit_r, bit_nxt;
  logic [31:0] dist_r, dist_nxt, len_r, len_nxt;

  logic [30:0] p_eff;
  logic [31:0] den;
  logic signed [34:0] num;
  logic [63:0] su_a, su_b, su_diff;
  logic        su_ge;
  logic [31:0] r_fix;
  logic signed [32:0] t_fix;
  logic [30:0] mag;
  logic [32:0] fog_sum;

  assign p_eff = (period == 31'd0) ? 31'd1 : period;
  assign den   = {p_eff, 1'b0};

  logic [1:0] axis_ld;
  logic signed [31:0] org_ld, cam_ld;
  always_comb begin
    axis_ld = (state_r == S_IDLE) ? 2'd0 : axis_r + 2'd1;
    case (axis_ld)
      2'd0: begin
        org_ld = org_x;
        cam_ld = cam_x;
      end
      2'd1: begin
        org_ld = org_y;
        cam_ld = cam_y;
      end
      default: begin
        org_ld = org_z;
        cam_ld = cam_z;
      end
    endcase
    num = ((35'(org_ld) - 35'(cam_ld)) <<< 1) + 35'(signed'({1'b0, p_eff}));
  end

  pfdc_sub u_sub (
    .a    (su_a),
    .b    (su_b),
    .ge   (su_ge),
    .diff (su_diff)
  );

  always_comb begin
    if (state_r == S_DIV) begin
      su_a = {31'd0, rem_r, nsh_r[33]};
      su_b = {32'd0, den};
    end else begin
      su_a = v_r;
      su_b = res_r | bit_r;
    end
  end

  assign r_fix = (neg_r && rem_r != 32'd0) ? den - rem_r : rem_r;
  assign t_fix = signed'({1'b0, r_fix}) - signed'({2'b0, p_eff});

  always_comb begin
    case (cnt_r[2:0])
      3'd0: mag = wd_r[0][31] ? 31'(-wd_r[0]) : wd_r[0][30:0];
      3'd1: mag = wd_r[1][31] ? 31'(-wd_r[1]) : wd_r[1][30:0];
      3'd2: mag = wd_r[2][31] ? 31'(-wd_r[2]) : wd_r[2][30:0];
      3'd3: mag = siz_x;
      3'd4: mag = siz_y;
      default: mag = siz_z;
    endcase
  end

  assign fog_sum = {2'b0, fog} + {2'b0, len_r[31:1]} + {17'd0, TENTH_Q16};

  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    cnt_nxt   = cnt_r;
    rsel_nxt  = rsel_r;
    nsh_nxt   = nsh_r;
    neg_nxt   = neg_r;
    rem_nxt   = rem_r;
    wd_nxt    = t_fix[32:1];
    wd_we     = 1'b0;
    dsum_nxt  = dsum_r;
    ssum_nxt  = ssum_r;
    v_nxt     = v_r;
    res_nxt   = res_r;
    bit_nxt   = bit_r;
    dist_nxt  = dist_r;
    len_nxt   = len_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_DIV;
          axis_nxt  = 2'd0;
          cnt_nxt   = 6'd0;
          neg_nxt   = num[34];
          nsh_nxt   = num[34] ? 34'(-num) : num[33:0];
          rem_nxt   = 32'd0;
        end
      end
      S_DIV: begin
        rem_nxt = su_ge ? su_diff[31:0] : su_a[31:0];
        nsh_nxt = {nsh_r[32:0], 1'b0};
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd33) begin
          state_nxt = S_FIX;
        end
      end
      S_FIX: begin
        wd_we = 1'b1;
        cnt_nxt = 6'd0;
        if (axis_r == 2'd2) begin
          state_nxt = S_MUL;
          dsum_nxt  = 64'd0;
          ssum_nxt  = 64'd0;
        end else begin
          state_nxt = S_DIV;
          axis_nxt  = axis_ld;
          neg_nxt   = num[34];
          nsh_nxt   = num[34] ? 34'(-num) : num[33:0];
          rem_nxt   = 32'd0;
        end
      end
      S_MUL: begin
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r >= 6'd1 && cnt_r <= 6'd3) begin
          dsum_nxt = dsum_r + {2'b0, prod_r};
        end else if (cnt_r >= 6'd4) begin
          ssum_nxt = ssum_r + {2'b0, prod_r};
        end
        if (cnt_r == 6'd6) begin
          state_nxt = S_ROOT;
          cnt_nxt   = 6'd0;
          rsel_nxt  = 1'b0;
          v_nxt     = dsum_r;
          res_nxt   = 64'd0;
          bit_nxt   = 64'd1 << 62;
        end
      end
      S_ROOT: begin
        if (su_ge) begin
          v_nxt   = su_diff;
          res_nxt = (res_r >> 1) | bit_r;
        end else begin
          res_nxt = res_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd31) begin
          cnt_nxt = 6'd0;
          if (!rsel_r) begin
            dist_nxt = res_nxt[31:0];
            rsel_nxt = 1'b1;
            v_nxt    = ssum_r;
            res_nxt  = 64'd0;
            bit_nxt  = 64'd1 << 62;
          end else begin
            len_nxt   = res_nxt[31:0];
            state_nxt = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (take) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      axis_r  <= 2'd0;
      cnt_r   <= 6'd0;
      rsel_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
      cnt_r   <= cnt_nxt;
      rsel_r  <= rsel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    nsh_r  <= nsh_nxt;
    neg_r  <= neg_nxt;
    rem_r  <= rem_nxt;
    dsum_r <= dsum_nxt;
    ssum_r <= ssum_nxt;
    v_r    <= v_nxt;
    res_r  <= res_nxt;
    bit_r  <= bit_nxt;
    dist_r <= dist_nxt;
    len_r  <= len_nxt;
    prod_r <= {31'd0, mag} * {31'd0, mag};
    if (wd_we) begin
      wd_r[axis_r] <= wd_nxt;
    end
  end

  assign idle         = (state_r == S_IDLE);
  assign stat.done    = (state_r == S_DONE);
  assign stat.visible = ({1'b0, dist_r} <= fog_sum);

endmodule

// ===== sim/tb.sv =====
// testbench for periodic_fog_distance_cull: reset-default, directed, random and back-pressure tests
// checks every result item against a cycle-free predictor of the cull and slot logic
// depends on pfdc_pkg and the periodic_fog_distance_cull rtl
`timescale 1ns / 1ps

module tb;
  import pfdc_pkg::*;

  localparam int ROOT_CAP = 131072;
  localparam logic [CFG_AW-1:0] REG_UNUSED = 3'd7;
  localparam longint CYCLE_LIMIT = 3000000;
  localparam logic [63:0] TENTH = 64'd6554;

  typedef struct {
    logic signed [31:0] ox, oy, oz;
    logic [30:0] sx, sy, sz;
    logic first;
  } inst_t;

  typedef struct {
    logic keep;
    logic [16:0] slot;
    logic [17:0] total;
    logic full;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DW-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DW-1:0] out_tdata;
  logic cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [CFG_DW-1:0] cfg_wdata = '0;

  // predictor copy of registers and state
  logic signed [31:0] cam_x, cam_y, cam_z;
  logic [30:0] fog_end, period;
  logic [17:0] base_slot, slot_cap, kept_cnt;

  verdict_t verdict_q[$];
  int errors = 0;
  longint cycles = 0;
  int hold_left = 0;
  bit no_idle = 0;

  periodic_fog_distance_cull u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic report(input string msg);
    if (errors < 50) $display("mismatch: %s", msg);
    errors++;
  endtask

  function automatic longint wrap_off(input longint d, input longint p);
    longint num, den, q;
    num = 2 * d + p;
    den = 2 * p;
    q = num / den;
    if ((num % den) != 0 && num < 0) q = q - 1;
    return d - q * p;
  endfunction

  function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'h1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic verdict_t cull_and_place(input inst_t it);
    longint p, dx, dy, dz, margin, radius;
    logic [63:0] dsum, ssum, ax, ay, az, dist_v, len;
    int bc, room, lim;
    verdict_t v;
    p = (period == 0) ? 1 : longint'(period);
    dx = wrap_off(longint'(it.ox) - longint'(cam_x), p);
    dy = wrap_off(longint'(it.oy) - longint'(cam_y), p);
    dz = wrap_off(longint'(it.oz) - longint'(cam_z), p);
    if (it.first) kept_cnt = 0;
    dsum = dx * dx + dy * dy + dz * dz;
    dist_v = floor_sqrt(dsum);
    ax = it.sx;
    ay = it.sy;
    az = it.sz;
    ssum = ax * ax + ay * ay + az * az;
    len = floor_sqrt(ssum);
    radius = longint'((len >> 1) + TENTH);
    margin = longint'(dist_v) - radius;
    bc = (base_slot < ROOT_CAP) ? int'(base_slot) : ROOT_CAP;
    room = ROOT_CAP - bc;
    lim = (int'(slot_cap) < room) ? int'(slot_cap) : room;
    v.keep = 0;
    v.slot = 0;
    if (margin <= longint'({33'b0, fog_end}) && int'(kept_cnt) < lim) begin
      v.keep = 1;
      v.slot = 17'(bc + int'(kept_cnt));
      kept_cnt = kept_cnt + 1;
    end
    v.total = kept_cnt;
    v.full = (int'(kept_cnt) >= lim);
    return v;
  endfunction

  function automatic inst_t mk(input logic [31:0] ox, oy, oz, input logic [30:0] sx, sy, sz,
                               input logic first);
    inst_t it;
    it.ox = ox; it.oy = oy; it.oz = oz;
    it.sx = sx; it.sy = sy; it.sz = sz;
    it.first = first;
    return it;
  endfunction

  task automatic send_item(input inst_t it);
    int n;
    n = no_idle ? 0 : $urandom_range(0, 3);
    if (n > 0) begin
      in_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    // origin_x, origin_y, origin_z, size_x, size_y, size_z, zero fill
    in_tdata <= {3'b0, it.sz, it.sy, it.sx, it.oz, it.oy, it.ox};
    in_tuser <= it.first;
    do @(posedge clk); while (!in_tready);
    verdict_q.insert(verdict_q.size(), cull_and_place(it));
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic set_reg(input logic [CFG_AW-1:0] idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_CAM_X: cam_x = val;
      REG_CAM_Y: cam_y = val;
      REG_CAM_Z: cam_z = val;
      REG_FOG: fog_end = val[30:0];
      REG_PERIOD: period = val[30:0];
      REG_BASE: base_slot = val[17:0];
      REG_LIMIT: slot_cap = val[17:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // result side: random stalls plus an optional long hold-off
  initial begin
    int gap;
    gap = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (gap > 0) begin
        out_tready <= 1'b0;
        gap--;
      end else begin
        out_tready <= 1'b1;
        if (out_tvalid && out_tready) gap = no_idle ? 0 : $urandom_range(0, 3);
      end
    end
  end

  always @(posedge clk) begin
    verdict_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (verdict_q.size() == 0) begin
        report("result item with nothing expected");
      end else begin
        e = verdict_q.pop_front();
        // keep, slot, kept_total, range_full, zero fill
        if (out_tdata[0] !== e.keep)
          report($sformatf("keep got %0b exp %0b", out_tdata[0], e.keep));
        if (out_tdata[17:1] !== e.slot)
          report($sformatf("slot got %0d exp %0d", out_tdata[17:1], e.slot));
        if (out_tdata[35:18] !== e.total)
          report($sformatf("kept_total got %0d exp %0d", out_tdata[35:18], e.total));
        if (out_tdata[36] !== e.full)
          report($sformatf("range_full got %0b exp %0b", out_tdata[36], e.full));
      end
    end
  end

  function automatic logic [30:0] rand_size();
    return 31'($urandom >> $urandom_range(1, 31));
  endfunction

  task automatic test_reset_defaults();
    send_item(mk(0, 0, 0, 0, 0, 0, 1'b1));
    send_item(mk(32'h7fffffff, 32'h80000000, 1, 31'h7fffffff, 0, 0, 1'b0));
    drain();
  endtask

  task automatic test_directed();
    // zero period folds every offset to zero, base near the top of the root range
    set_reg(REG_PERIOD, 0);
    set_reg(REG_FOG, 0);
    set_reg(REG_BASE, 131071);
    set_reg(REG_LIMIT, 3);
    send_item(mk(32'h80000000, 32'h7fffffff, 0, 0, 0, 0, 1'b1));
    send_item(mk(5, 6, 7, 0, 0, 0, 1'b0));
    send_item(mk(5, 6, 7, 31'h7fffffff, 31'h7fffffff, 31'h7fffffff, 1'b1));
    drain();
    // base at and beyond the root capacity leaves no room
    set_reg(REG_BASE, 131072);
    send_item(mk(0, 0, 0, 0, 0, 0, 1'b1));
    drain();
    set_reg(REG_BASE, 32'hffffffff);
    set_reg(REG_UNUSED, 32'h0);
    send_item(mk(0, 0, 0, 0, 0, 0, 1'b1));
    drain();
    // widest period, camera at the extremes, fog at both ends
    set_reg(REG_BASE, 0);
    set_reg(REG_LIMIT, 32'h3ffff);
    set_reg(REG_PERIOD, 32'h7fffffff);
    set_reg(REG_CAM_X, 32'h80000000);
    set_reg(REG_CAM_Y, 32'h7fffffff);
    set_reg(REG_CAM_Z, 32'h00000000);
    send_item(mk(32'h7fffffff, 32'h80000000, 32'h40000000, 0, 0, 0, 1'b1));
    send_item(mk(32'h80000000, 32'h7fffffff, 32'hc0000000, 31'h7fffffff, 31'h7fffffff,
                 31'h7fffffff, 1'b0));
    send_item(mk(32'hffffffff, 32'h00000000, 32'h3fffffff, 1, 1, 1, 1'b0));
    drain();
    set_reg(REG_FOG, 32'h7fffffff);
    send_item(mk(32'h7fffffff, 32'h80000000, 32'h40000000, 0, 0, 0, 1'b0));
    send_item(mk(32'h00010000, 32'h7fff0000, 32'h80000000, 31'h00010000, 0, 31'h7fffffff,
                 1'b0));
    drain();
    // small limit so the range fills and later items are dropped
    set_reg(REG_PERIOD, 32'h00100000);
    set_reg(REG_LIMIT, 2);
    set_reg(REG_BASE, 100);
    repeat (4) send_item(mk($urandom, $urandom, $urandom, rand_size(), rand_size(),
                            rand_size(), 1'b0));
    send_item(mk(0, 0, 0, 0, 0, 0, 1'b1));
    drain();
  endtask

  task automatic random_config();
    int sel;
    set_reg(REG_CAM_X, ($urandom_range(0, 1)) ? $urandom : $urandom >> 12);
    set_reg(REG_CAM_Y, ($urandom_range(0, 1)) ? $urandom : $urandom >> 12);
    set_reg(REG_CAM_Z, ($urandom_range(0, 1)) ? $urandom : $urandom >> 12);
    sel = $urandom_range(0, 9);
    if (sel == 0) set_reg(REG_PERIOD, 0);
    else if (sel < 3) set_reg(REG_PERIOD, $urandom >> 1);
    else set_reg(REG_PERIOD, $urandom_range(1, 32'h01000000));
    sel = $urandom_range(0, 9);
    if (sel == 0) set_reg(REG_FOG, 32'h7fffffff);
    else if (sel == 1) set_reg(REG_FOG, 0);
    else set_reg(REG_FOG, $urandom_range(0, period));
    sel = $urandom_range(0, 5);
    if (sel == 0) set_reg(REG_BASE, $urandom_range(131000, 131072));
    else if (sel == 1) set_reg(REG_BASE, $urandom);
    else set_reg(REG_BASE, $urandom_range(0, 131072));
    sel = $urandom_range(0, 5);
    if (sel == 0) set_reg(REG_LIMIT, $urandom);
    else set_reg(REG_LIMIT, $urandom_range(0, 40));
  endtask

  task automatic test_random();
    int n, len;
    logic [31:0] spread;
    for (int ph = 0; ph < 6; ph++) begin
      no_idle = (ph == 3);
      random_config();
      n = 0;
      while (n < 240) begin
        len = $urandom_range(1, 60);
        spread = 32'({1'b0, period} >> $urandom_range(0, 4));
        for (int i = 0; i < len; i++) begin
          inst_t it;
          if ($urandom_range(0, 9) == 0) begin
            it = mk($urandom, $urandom, $urandom, 31'($urandom), 31'($urandom),
                    31'($urandom), 1'($urandom_range(0, 1)));
          end else begin
            it = mk(cam_x + 32'($urandom_range(0, spread) - spread / 2),
                    cam_y + 32'($urandom_range(0, spread) - spread / 2),
                    cam_z + 32'($urandom_range(0, spread) - spread / 2),
                    rand_size(), rand_size(), rand_size(), i == 0);
          end
          send_item(it);
          n++;
        end
      end
      drain();
    end
    no_idle = 0;
  endtask

  task automatic test_backpressure();
    set_reg(REG_LIMIT, 10);
    hold_left = 3000;
    for (int i = 0; i < 16; i++)
      send_item(mk($urandom, $urandom, $urandom, rand_size(), rand_size(), rand_size(),
                   i == 0));
    drain();
  endtask

  initial begin
    cam_x = 0; cam_y = 0; cam_z = 0;
    fog_end = 0; period = PERIOD_RESET;
    base_slot = 0; slot_cap = 0; kept_cnt = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_directed();
    test_random();
    test_backpressure();
    repeat (400) @(posedge clk);
    if (errors == 0 && verdict_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
